@@ hdl/word_category_bigram_histogram_macros.svh @@
// ----------------------------------------------------------------------------
// word_category_bigram_histogram_macros.svh
// Assertion macros for the word category bigram histogram.
// ----------------------------------------------------------------------------
`ifndef WORD_CATEGORY_BIGRAM_HISTOGRAM_MACROS_SVH
`define WORD_CATEGORY_BIGRAM_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
// a implies b in the same cycle
`define WCBH_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// a implies b in the next cycle
`define WCBH_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define WCBH_ASSERT_IMPLY(label, clk, rst, a, b, msg)
`define WCBH_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

@@ hdl/wcbh_pkg.sv @@
// ----------------------------------------------------------------------------
// wcbh_pkg
// Shared types and constants of the word category bigram histogram.
// ----------------------------------------------------------------------------
package wcbh_pkg;

   localparam int WORDS_DEFAULT      = 4096;
   localparam int CATEGORIES_DEFAULT = 16;
   localparam int COUNT_BITS_DEFAULT = 24;

   localparam int WORD_W     = 12;
   localparam int CATEGORY_W = 4;
   localparam int RATIO_W    = 17;
   localparam int FIELD_W    = 24;
   localparam int FRAC_BITS  = 16;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_FEED  = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_FETCH,
      ST_DIVIDE,
      ST_RESULT
   } back_state_type;

   typedef struct packed {
      logic [1:0]            func;
      logic [WORD_W-1:0]     word;
      logic [CATEGORY_W-1:0] category;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic               no_occurrence;
      logic [FIELD_W-1:0] pair_count;
      logic [FIELD_W-1:0] word_count;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      func_type              op;
      logic [WORD_W-1:0]     word;
      logic [CATEGORY_W-1:0] category;
      logic                  word_ok;
      logic                  cat_ok;
   } cmd_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage

@@ hdl/wcbh_queue.sv @@
// ----------------------------------------------------------------------------
// wcbh_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module wcbh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wcbh_pkg::cmd_type push_cmd,
   output logic              push_ready,
   input  logic              pop,
   output logic              head_valid,
   output wcbh_pkg::cmd_type head_cmd
);
   import wcbh_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/wcbh_front.sv @@
// ----------------------------------------------------------------------------
// wcbh_front
// Accepts request transactions, range-checks them, drops no-op ones.
// ----------------------------------------------------------------------------
module wcbh_front #(
   parameter int WORDS      = wcbh_pkg::WORDS_DEFAULT,
   parameter int CATEGORIES = wcbh_pkg::CATEGORIES_DEFAULT
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wcbh_pkg::req_type         req_data,
   input  wcbh_pkg::back_status_type status,
   input  logic                      push_ready,
   output logic                      push,
   output wcbh_pkg::cmd_type         push_cmd
);
   import wcbh_pkg::*;

   logic word_ok, cat_ok, keep;
   func_type op;

   always_comb begin
      op      = func_type'(req_data.func);
      word_ok = (32'(req_data.word) < WORDS);
      cat_ok  = (32'(req_data.category) < CATEGORIES);
      case (op)
         FUNC_LOAD:  keep = word_ok && cat_ok;
         FUNC_FEED:  keep = word_ok;
         FUNC_READ:  keep = 1'b1;
         FUNC_CLEAR: keep = 1'b1;
         default:    keep = 1'b0;
      endcase
   end

   assign req_ready         = push_ready && !status.init_busy;
   assign push              = req_valid && req_ready && keep;
   assign push_cmd.op       = op;
   assign push_cmd.word     = req_data.word;
   assign push_cmd.category = req_data.category;
   assign push_cmd.word_ok  = word_ok;
   assign push_cmd.cat_ok   = cat_ok;

endmodule

@@ hdl/wcbh_divider.sv @@
// ----------------------------------------------------------------------------
// wcbh_divider
// Restoring divider, one quotient bit per cycle, for dividend < divisor.
// ----------------------------------------------------------------------------
module wcbh_divider #(
   parameter int COUNT_BITS = wcbh_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [COUNT_BITS-1:0]             dividend,
   input  logic [COUNT_BITS-1:0]             divisor,
   output logic                              done,
   output logic [wcbh_pkg::FRAC_BITS-1:0]    quotient
);
   import wcbh_pkg::*;

   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   logic [COUNT_BITS:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0] div_ff;
   logic [FRAC_BITS-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COUNT_BITS:0]   shifted;
   logic                  fits;

   always_comb begin
      shifted = {rem_ff[COUNT_BITS-1:0], 1'b0};
      fits    = (shifted >= {1'b0, div_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, dividend};
         quo_in  = '0;
         step_in = STEP_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (shifted - {1'b0, div_ff}) : shifted;
         quo_in  = {quo_ff[FRAC_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/wcbh_back.sv @@
// ----------------------------------------------------------------------------
// wcbh_back
// Executes commands against the map and counter memories, builds results.
// ----------------------------------------------------------------------------
module wcbh_back #(
   parameter int WORDS      = wcbh_pkg::WORDS_DEFAULT,
   parameter int CATEGORIES = wcbh_pkg::CATEGORIES_DEFAULT,
   parameter int COUNT_BITS = wcbh_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  wcbh_pkg::cmd_type         head_cmd,
   output logic                      pop,
   output wcbh_pkg::back_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wcbh_pkg::rsp_type         rsp_data
);
   import wcbh_pkg::*;

   localparam int WB = $clog2(WORDS);
   localparam int CB = $clog2(CATEGORIES);
   localparam int RW = CATEGORIES * COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_BITS-1:0] c);
      logic [31:0] t;
      t = 32'(c);
      return t[FIELD_W-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   logic [CB-1:0]         map_mem  [WORDS];
   logic [COUNT_BITS-1:0] occ_mem  [WORDS];
   logic [RW-1:0]         pair_mem [WORDS];

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff;
   logic [WB-1:0]  sweep_ff, sweep_in;
   logic           clear_map_ff, clear_map_in;
   logic [CB-1:0]  prev_cat_ff, prev_cat_in;
   logic           prev_valid_ff, prev_valid_in;
   rsp_type        rsp_ff;

   logic [CB-1:0]         map_rd_ff;
   logic [COUNT_BITS-1:0] occ_rd_ff;
   logic [RW-1:0]         row_rd_ff;

   logic [31:0]           head_w32, ff_w32, head_c32, ff_c32;
   logic [WB-1:0]         addr;
   logic                  map_we, occ_we, pair_we;
   logic [CB-1:0]         map_wd;
   logic [COUNT_BITS-1:0] occ_wd;
   logic [RW-1:0]         row_wd;
   logic [CB-1:0]         ff_ci;
   logic [COUNT_BITS-1:0] occ_v, pair_v;
   logic                  sweep_last;
   logic                  div_start, div_done;
   logic [FRAC_BITS-1:0]  div_q;
   logic                  head_go;

   always_comb begin
      head_w32   = 32'(head_cmd.word);
      ff_w32     = 32'(cmd_ff.word);
      head_c32   = 32'(head_cmd.category);
      ff_c32     = 32'(cmd_ff.category);
      ff_ci      = ff_c32[CB-1:0];
      sweep_last = (sweep_ff == WB'(WORDS - 1));
      head_go    = (state_ff == ST_IDLE) && head_valid;
      occ_v      = cmd_ff.word_ok ? occ_rd_ff : '0;
      pair_v     = (cmd_ff.word_ok && cmd_ff.cat_ok) ?
                   row_rd_ff[ff_ci*COUNT_BITS +: COUNT_BITS] : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP:  if (sweep_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (head_valid) begin
               case (head_cmd.op)
                  FUNC_FEED:  state_in = ST_FETCH;
                  FUNC_READ:  state_in = ST_FETCH;
                  FUNC_CLEAR: state_in = ST_SWEEP;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: begin
            if (cmd_ff.op != FUNC_READ) begin
               state_in = ST_IDLE;
            end else if (occ_v != '0 && pair_v < occ_v) begin
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_DIVIDE: if (div_done) state_in = ST_RESULT;
         ST_RESULT: if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_SWEEP;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      pop       = head_go;
      addr      = ff_w32[WB-1:0];
      map_we    = 1'b0;
      occ_we    = 1'b0;
      pair_we   = 1'b0;
      map_wd    = head_c32[CB-1:0];
      occ_wd    = sat_inc(occ_rd_ff);
      row_wd    = row_rd_ff;
      row_wd[prev_cat_ff*COUNT_BITS +: COUNT_BITS] =
         sat_inc(row_rd_ff[prev_cat_ff*COUNT_BITS +: COUNT_BITS]);
      div_start = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            addr    = sweep_ff;
            map_we  = clear_map_ff;
            map_wd  = '0;
            occ_we  = 1'b1;
            occ_wd  = '0;
            pair_we = 1'b1;
            row_wd  = '0;
         end
         ST_IDLE: begin
            addr   = head_w32[WB-1:0];
            map_we = head_valid && (head_cmd.op == FUNC_LOAD);
         end
         ST_FETCH: begin
            occ_we    = (cmd_ff.op == FUNC_FEED);
            pair_we   = (cmd_ff.op == FUNC_FEED) && prev_valid_ff;
            div_start = (cmd_ff.op == FUNC_READ) && (state_in == ST_DIVIDE);
         end
         default: begin
         end
      endcase
   end

   // predecessor and sweep bookkeeping
   always_comb begin
      sweep_in      = sweep_ff;
      clear_map_in  = clear_map_ff;
      prev_cat_in   = prev_cat_ff;
      prev_valid_in = prev_valid_ff;
      if (state_ff == ST_SWEEP) begin
         sweep_in = sweep_ff + 1'b1;
         if (sweep_last) clear_map_in = 1'b0;
      end
      if (head_go && head_cmd.op == FUNC_CLEAR) begin
         sweep_in      = '0;
         prev_cat_in   = '0;
         prev_valid_in = 1'b0;
      end
      if (state_ff == ST_FETCH && cmd_ff.op == FUNC_FEED) begin
         prev_cat_in   = map_rd_ff;
         prev_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         sweep_ff      <= '0;
         clear_map_ff  <= 1'b1;
         prev_cat_ff   <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         clear_map_ff  <= clear_map_in;
         prev_cat_ff   <= prev_cat_in;
         prev_valid_ff <= prev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_go) cmd_ff <= head_cmd;
      if (state_ff == ST_FETCH) begin
         rsp_ff.no_occurrence <= (occ_v == '0);
         rsp_ff.pair_count    <= to_field(pair_v);
         rsp_ff.word_count    <= to_field(occ_v);
         rsp_ff.ratio         <= (occ_v == '0) ? '0 :
                                 (pair_v >= occ_v) ? RATIO_W'(1 << FRAC_BITS) : '0;
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         rsp_ff.ratio <= {1'b0, div_q};
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[addr] <= map_wd;
      map_rd_ff <= map_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[addr] <= occ_wd;
      occ_rd_ff <= occ_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (pair_we) pair_mem[addr] <= row_wd;
      row_rd_ff <= pair_mem[addr];
   end

   wcbh_divider #(
      .COUNT_BITS(COUNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pair_v),
      .divisor  (occ_v),
      .done     (div_done),
      .quotient (div_q)
   );

   assign status.init_busy = (state_ff == ST_SWEEP) && clear_map_ff;
   assign rsp_valid        = (state_ff == ST_RESULT);
   assign rsp_data         = rsp_ff;

endmodule

@@ hdl/word_category_bigram_histogram.sv @@
// ----------------------------------------------------------------------------
// word_category_bigram_histogram
// Word-to-category map with per-word occurrence and category bigram counts.
//
//   channel  direction  payload                      handshake
//   req_     in         func, word, category         req_valid / req_ready
//   rsp_     out        ratio, no_occurrence, counts rsp_valid / rsp_ready
//
// Load writes the map on accept; feed reads the memories, then writes back;
// read fetches, runs the serial divider if needed, then holds the result;
// clear sweeps all rows. After reset a sweep zeroes all memories and
// holds req_ready low. A two-entry queue decouples the front, so requests
// keep landing while a result waits on rsp_ready or a clear sweep runs.
// ----------------------------------------------------------------------------
`include "word_category_bigram_histogram_macros.svh"

module word_category_bigram_histogram #(
   parameter int WORDS      = wcbh_pkg::WORDS_DEFAULT,
   parameter int CATEGORIES = wcbh_pkg::CATEGORIES_DEFAULT,
   parameter int COUNT_BITS = wcbh_pkg::COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wcbh_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wcbh_pkg::rsp_type rsp_data
);
   import wcbh_pkg::*;

   back_status_type status;
   logic            push, push_ready, pop, head_valid;
   cmd_type         push_cmd, head_cmd;

   // front: classify and drop transactions that change nothing
   wcbh_front #(
      .WORDS      (WORDS),
      .CATEGORIES (CATEGORIES)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .status     (status),
      .push_ready (push_ready),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   wcbh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: memories, predecessor state, divider, result register
   wcbh_back #(
      .WORDS      (WORDS),
      .CATEGORIES (CATEGORIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   `WCBH_ASSERT_IMPLY(a_no_occ_zero, clock, reset, rsp_valid && rsp_data.no_occurrence, rsp_data.ratio == '0 && rsp_data.pair_count == '0, "no_occurrence with nonzero ratio or pair count")
   `WCBH_ASSERT_IMPLY(a_ratio_max, clock, reset, rsp_valid, rsp_data.ratio <= 17'd65536, "ratio above one")
   `WCBH_ASSERT_IMPLY(a_init_stall, clock, reset, status.init_busy, !req_ready, "request taken during init sweep")
   `WCBH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result dropped or changed")

endmodule
